// ----- sv/gdrc_pkg.sv -----
`default_nettype none

package gdrc_pkg;

  // default sizes
  localparam int GRID_WIDTH_DEF     = 64;
  localparam int GRID_HEIGHT_DEF    = 64;
  localparam int SCREEN_COLUMNS_DEF = 1024;

  // field widths
  localparam int POS_W     = 22;
  localparam int DIR_W     = 18;
  localparam int COL_W     = 10;
  localparam int CELL_W    = 6;
  localparam int CODE_W    = 4;
  localparam int DIST_W    = 40;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;

  // internal widths
  localparam int CAM_W  = 28;
  localparam int PROD_W = CAM_W + DIR_W;
  localparam int RAY_W  = 31;
  localparam int NUM_W  = 33;
  localparam int DEN_W  = 31;
  localparam int F_W    = 17;

  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [CODE_W-1:0] WALL_CODE = 4'd1;
  localparam logic [F_W-1:0]    ONE_Q16   = 17'h1_0000;

  localparam logic [POS_W-1:0]        POS_X_RST   = '0;
  localparam logic [POS_W-1:0]        POS_Y_RST   = '0;
  localparam logic signed [DIR_W-1:0] DIR_X_RST   = 18'sd65536;
  localparam logic signed [DIR_W-1:0] DIR_Y_RST   = 18'sd0;
  localparam logic signed [DIR_W-1:0] PLANE_X_RST = 18'sd0;
  localparam logic signed [DIR_W-1:0] PLANE_Y_RST = 18'sd43254;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIV_CAM = 2'd0,
    DIV_DX  = 2'd1,
    DIV_DY  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     clr_step;
    logic     in_ready;
    logic     load_cast;
    logic     div_start;
    div_sel_t div_sel;
    logic     cam_take;
    logic     ray_mul;
    logic     ray_add;
    logic     dx_take;
    logic     dy_take;
    logic     init_side;
    logic     walk_step;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic in_cast;
    logic div_done;
    logic outside;
    logic hit;
    logic out_full;
    logic out_ready;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/gdrc_if.sv -----
`default_nettype none

interface gdrc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [gdrc_pkg::COL_W-1:0]    column;
  logic [gdrc_pkg::CELL_W-1:0]   cell_x;
  logic [gdrc_pkg::CELL_W-1:0]   cell_y;
  logic [gdrc_pkg::CODE_W-1:0]   cell_code;

  modport source(output valid, opcode, column, cell_x, cell_y, cell_code, input ready);
  modport sink(input valid, opcode, column, cell_x, cell_y, cell_code, output ready);
endinterface

interface gdrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [gdrc_pkg::CELL_W-1:0]   hit_x;
  logic [gdrc_pkg::CELL_W-1:0]   hit_y;
  logic                          hit_side;
  logic [gdrc_pkg::DIST_W-1:0]   dist_x_final;
  logic [gdrc_pkg::DIST_W-1:0]   dist_y_final;
  logic                          out_of_map;

  modport source(output valid, hit_x, hit_y, hit_side, dist_x_final, dist_y_final,
                 out_of_map, input ready);
  modport sink(input valid, hit_x, hit_y, hit_side, dist_x_final, dist_y_final,
               out_of_map, output ready);
endinterface

`default_nettype wire

// ----- sv/gdrc_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module gdrc_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [gdrc_pkg::NUM_W-1:0]    num,
  input  wire logic [gdrc_pkg::DEN_W-1:0]    den,
  output logic                               done,
  output logic [gdrc_pkg::NUM_W-1:0]         quot
);
  localparam int NW = gdrc_pkg::NUM_W;
  localparam int DW = gdrc_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] rem_r, rem_nxt, den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial    = {rem_r, dvd_r[NW-1]};
    ge       = (trial >= {1'b0, den_r});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[NW-2:0], ge};
      rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

`default_nettype wire

// ----- sv/gdrc_ctrl.sv -----
`default_nettype none

module gdrc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gdrc_pkg::dp_stat_t    stat,
  output gdrc_pkg::ctrl_cmd_t        cmd
);
  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_CAM   = 13'b0000000000100,
    ST_RAY_M = 13'b0000000001000,
    ST_RAY_A = 13'b0000000010000,
    ST_DX    = 13'b0000000100000,
    ST_DX_W  = 13'b0000001000000,
    ST_DY    = 13'b0000010000000,
    ST_DY_W  = 13'b0000100000000,
    ST_INIT  = 13'b0001000000000,
    ST_STEP  = 13'b0010000000000,
    ST_CHECK = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.div_sel = gdrc_pkg::DIV_CAM;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid && stat.in_cast) begin
          cmd.load_cast = 1'b1;
          state_nxt     = ST_CAM;
        end
      end
      ST_CAM: begin
        cmd.cam_take = 1'b1;
        state_nxt    = ST_RAY_M;
      end
      ST_RAY_M: begin
        cmd.ray_mul = 1'b1;
        state_nxt   = ST_RAY_A;
      end
      ST_RAY_A: begin
        cmd.ray_add = 1'b1;
        state_nxt   = ST_DX;
      end
      ST_DX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = gdrc_pkg::DIV_DX;
        state_nxt     = ST_DX_W;
      end
      ST_DX_W: begin
        if (stat.div_done) begin
          cmd.dx_take = 1'b1;
          state_nxt   = ST_DY;
        end
      end
      ST_DY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = gdrc_pkg::DIV_DY;
        state_nxt     = ST_DY_W;
      end
      ST_DY_W: begin
        if (stat.div_done) begin
          cmd.dy_take = 1'b1;
          state_nxt   = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_side = 1'b1;
        state_nxt     = stat.outside ? ST_DONE : ST_STEP;
      end
      ST_STEP: begin
        cmd.walk_step = 1'b1;
        state_nxt     = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.outside || stat.hit) state_nxt = ST_DONE;
        else state_nxt = ST_STEP;
      end
      ST_DONE: begin
        if (!stat.out_full || stat.out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == ST_DX_W || state_r == ST_DY_W))
    else $error("divider finished outside a wait state");

  a_check_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> $past(state_r) == ST_STEP)
    else $error("cell check without a step");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!stat.out_full || stat.out_ready)) |=> stat.out_full)
    else $error("result not held in output register");

endmodule

`default_nettype wire

// ----- sv/gdrc_dp.sv -----
`default_nettype none

module gdrc_dp #(
  parameter int GRID_WIDTH     = gdrc_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT    = gdrc_pkg::GRID_HEIGHT_DEF,
  parameter int SCREEN_COLUMNS = gdrc_pkg::SCREEN_COLUMNS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gdrc_pkg::ctrl_cmd_t               cmd,
  output gdrc_pkg::dp_stat_t                     stat,
  gdrc_in_if.sink                                in_ch,
  gdrc_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [gdrc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [gdrc_pkg::CFG_W-1:0]        cfg_wdata
);
  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MXW   = $clog2(GRID_WIDTH) + 2;
  localparam int MYW   = $clog2(GRID_HEIGHT) + 2;
  localparam int PW    = gdrc_pkg::POS_W;
  localparam int DRW   = gdrc_pkg::DIR_W;
  localparam int DSW   = gdrc_pkg::DIST_W;
  localparam int RW    = gdrc_pkg::RAY_W;
  localparam int CMW   = gdrc_pkg::CAM_W;
  localparam int PRW   = gdrc_pkg::PROD_W;
  localparam int NW    = gdrc_pkg::NUM_W;
  localparam int DNW   = gdrc_pkg::DEN_W;
  localparam int FW    = gdrc_pkg::F_W;
  localparam int FRW   = gdrc_pkg::FRAC_W;
  localparam int CLW   = gdrc_pkg::CELL_W;
  localparam int CDW   = gdrc_pkg::CODE_W;
  localparam logic signed [MXW-1:0] W_S = MXW'(GRID_WIDTH);
  localparam logic signed [MYW-1:0] H_S = MYW'(GRID_HEIGHT);

  // configuration
  logic [PW-1:0]         pos_x_r, pos_y_r;
  logic signed [DRW-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= gdrc_pkg::POS_X_RST;
      pos_y_r   <= gdrc_pkg::POS_Y_RST;
      dir_x_r   <= gdrc_pkg::DIR_X_RST;
      dir_y_r   <= gdrc_pkg::DIR_Y_RST;
      plane_x_r <= gdrc_pkg::PLANE_X_RST;
      plane_y_r <= gdrc_pkg::PLANE_Y_RST;
    end else if (cfg_we) begin
      case (gdrc_pkg::cfg_idx_t'(cfg_idx))
        gdrc_pkg::CFG_POS_X:   pos_x_r   <= cfg_wdata;
        gdrc_pkg::CFG_POS_Y:   pos_y_r   <= cfg_wdata;
        gdrc_pkg::CFG_DIR_X:   dir_x_r   <= cfg_wdata[DRW-1:0];
        gdrc_pkg::CFG_DIR_Y:   dir_y_r   <= cfg_wdata[DRW-1:0];
        gdrc_pkg::CFG_PLANE_X: plane_x_r <= cfg_wdata[DRW-1:0];
        gdrc_pkg::CFG_PLANE_Y: plane_y_r <= cfg_wdata[DRW-1:0];
        default: ;
      endcase
    end
  end

  // grid memory with clearing pass
  logic [CDW-1:0] mem [DEPTH];
  logic [AW-1:0]  clr_cnt_r;
  logic           mem_we, mem_re, wr_ok;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [CDW-1:0] mem_wdata, rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  assign wr_ok = (32'(in_ch.cell_x) < GRID_WIDTH) && (32'(in_ch.cell_y) < GRID_HEIGHT);
  assign mem_we = cmd.clr_step ||
                  (cmd.in_ready && in_ch.valid && in_ch.opcode == gdrc_pkg::OP_WRITE && wr_ok);
  assign mem_waddr = cmd.clr_step ? clr_cnt_r :
                     AW'(32'(in_ch.cell_y) * GRID_WIDTH + 32'(in_ch.cell_x));
  assign mem_wdata = cmd.clr_step ? '0 : in_ch.cell_code;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_r <= mem[mem_raddr];
  end

  // camera x by reciprocal multiplication, exact for every 10-bit column
  localparam int COL_WL = gdrc_pkg::COL_W;
  localparam int CNW    = COL_WL + FRW + 1;
  localparam int CAM_K  = CNW + $clog2(SCREEN_COLUMNS);
  localparam logic [63:0] CAM_RECIP_L =
    ((64'd1 << CAM_K) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS);
  localparam logic [CNW:0] CAM_RECIP = CAM_RECIP_L[CNW:0];

  logic [COL_WL-1:0] column_r;
  logic [2*CNW:0]    cam_prod;
  logic [CMW-2:0]    cam_q;

  assign cam_prod = (2*CNW+1)'({column_r, (FRW+1)'(0)}) * (2*CNW+1)'(CAM_RECIP);
  assign cam_q    = (CMW-1)'(cam_prod >> CAM_K);

  // divider for the delta distances
  logic [NW-1:0]  div_num, quot;
  logic [DNW-1:0] div_den;
  logic           div_done;
  logic [DNW-1:0] mag_x, mag_y;
  logic signed [RW-1:0] ray_x_r, ray_y_r;

  assign mag_x = ray_x_r[RW-1] ? DNW'(-ray_x_r) : DNW'(ray_x_r);
  assign mag_y = ray_y_r[RW-1] ? DNW'(-ray_y_r) : DNW'(ray_y_r);

  always_comb begin
    case (cmd.div_sel)
      gdrc_pkg::DIV_DX: begin
        div_num = NW'(33'h1_0000_0000);
        div_den = mag_x;
      end
      gdrc_pkg::DIV_DY: begin
        div_num = NW'(33'h1_0000_0000);
        div_den = mag_y;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gdrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // ray set-up
  logic signed [CMW-1:0] cam_r;
  logic signed [PRW-1:0] prod_x_r, prod_y_r;
  logic [DSW-1:0]        dx_r, dy_r, sx_r, sy_r;
  logic                  zx_r, zy_r;
  logic signed [MXW-1:0] mx_r, mx_n;
  logic signed [MYW-1:0] my_r, my_n;
  logic                  outside_r, side_r;
  logic [FW-1:0]         fx, fy;
  logic [DSW:0]          sum_x, sum_y;
  logic                  step_x, oob;

  assign fx = ray_x_r[RW-1] ? FW'(pos_x_r[FRW-1:0]) : gdrc_pkg::ONE_Q16 - FW'(pos_x_r[FRW-1:0]);
  assign fy = ray_y_r[RW-1] ? FW'(pos_y_r[FRW-1:0]) : gdrc_pkg::ONE_Q16 - FW'(pos_y_r[FRW-1:0]);

  assign step_x = sx_r < sy_r;
  assign sum_x  = {1'b0, sx_r} + {1'b0, dx_r};
  assign sum_y  = {1'b0, sy_r} + {1'b0, dy_r};
  assign mx_n   = step_x ? (ray_x_r[RW-1] ? mx_r - 1'b1 : mx_r + 1'b1) : mx_r;
  assign my_n   = step_x ? my_r : (ray_y_r[RW-1] ? my_r - 1'b1 : my_r + 1'b1);
  assign oob    = (mx_n < 0) || (mx_n >= W_S) || (my_n < 0) || (my_n >= H_S);
  assign mem_re = cmd.walk_step && !oob;
  assign mem_raddr = AW'(32'(unsigned'(my_n)) * GRID_WIDTH + 32'(unsigned'(mx_n)));

  always_ff @(posedge clk) begin
    if (cmd.load_cast) column_r <= in_ch.column;
    if (cmd.cam_take) cam_r <= signed'({1'b0, cam_q}) - CMW'(65536);
    if (cmd.ray_mul) begin
      prod_x_r <= PRW'(plane_x_r) * PRW'(cam_r);
      prod_y_r <= PRW'(plane_y_r) * PRW'(cam_r);
    end
    if (cmd.ray_add) begin
      ray_x_r   <= RW'(dir_x_r) + RW'(prod_x_r >>> FRW);
      ray_y_r   <= RW'(dir_y_r) + RW'(prod_y_r >>> FRW);
      mx_r      <= MXW'(signed'({1'b0, pos_x_r[PW-1:FRW]}));
      my_r      <= MYW'(signed'({1'b0, pos_y_r[PW-1:FRW]}));
      outside_r <= (32'(pos_x_r[PW-1:FRW]) >= GRID_WIDTH) ||
                   (32'(pos_y_r[PW-1:FRW]) >= GRID_HEIGHT);
      side_r    <= 1'b0;
    end
    if (cmd.dx_take) begin
      zx_r <= (mag_x == '0);
      dx_r <= (mag_x == '0) ? gdrc_pkg::DIST_MAX : DSW'(quot);
    end
    if (cmd.dy_take) begin
      zy_r <= (mag_y == '0);
      dy_r <= (mag_y == '0) ? gdrc_pkg::DIST_MAX : DSW'(quot);
    end
    if (cmd.init_side) begin
      // zero ray: f * (2^40 - 1) >> 16 reduces to (f << 24) - 1
      sx_r <= zx_r ? DSW'({fx, 24'b0} - 1'b1) :
                     DSW'(((FW+NW)'(fx) * (FW+NW)'(dx_r[NW-1:0])) >> FRW);
      sy_r <= zy_r ? DSW'({fy, 24'b0} - 1'b1) :
                     DSW'(((FW+NW)'(fy) * (FW+NW)'(dy_r[NW-1:0])) >> FRW);
    end
    if (cmd.walk_step) begin
      if (step_x) sx_r <= sum_x[DSW] ? gdrc_pkg::DIST_MAX : sum_x[DSW-1:0];
      else sy_r <= sum_y[DSW] ? gdrc_pkg::DIST_MAX : sum_y[DSW-1:0];
      mx_r      <= mx_n;
      my_r      <= my_n;
      side_r    <= !step_x;
      outside_r <= oob;
    end
  end

  // output register
  logic                 out_valid_r;
  logic [CLW-1:0]       hit_x_r, hit_y_r;
  logic                 hit_side_r, oom_r;
  logic [DSW-1:0]       dxf_r, dyf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit_x_r    <= outside_r ? '0 : CLW'(mx_r);
      hit_y_r    <= outside_r ? '0 : CLW'(my_r);
      hit_side_r <= side_r;
      dxf_r      <= sx_r;
      dyf_r      <= sy_r;
      oom_r      <= outside_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit_x        = hit_x_r;
  assign out_ch.hit_y        = hit_y_r;
  assign out_ch.hit_side     = hit_side_r;
  assign out_ch.dist_x_final = dxf_r;
  assign out_ch.dist_y_final = dyf_r;
  assign out_ch.out_of_map   = oom_r;
  assign in_ch.ready         = cmd.in_ready;

  assign stat.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
  assign stat.in_valid  = in_ch.valid;
  assign stat.in_cast   = (in_ch.opcode == gdrc_pkg::OP_CAST);
  assign stat.div_done  = div_done;
  assign stat.outside   = outside_r;
  assign stat.hit       = (rd_r == gdrc_pkg::WALL_CODE);
  assign stat.out_full  = out_valid_r;
  assign stat.out_ready = out_ch.ready;

endmodule

`default_nettype wire

// ----- sv/grid_dda_ray_caster.sv -----
`default_nettype none

// grid ray caster: a grid of 4-bit cell codes and a dda walk over it
// in_ch carries one item per transfer: opcode 0 stores cell_code at (cell_x, cell_y),
//   opcode 1 casts a ray for screen column and gives one result on out_ch
// cfg_* writes one viewer register (pos, dir, plane) per cycle with cfg_we high
// a cell write gives no result
// a cast's result follows camera x and ray set-up, both delta distances in turn on the
//   shared bit-serial divider, side set-up, the walk and the hand-off; every step of the
//   walk waits on the registered read of the grid memory; the next item can transfer
//   once the result is loaded into the output register
// one item is in work at a time; in_ch.ready is high only while the block waits for work
// a finished result sits in the output register, so the next item is taken while
//   the receiver stalls; only a second result waits for out_ch.ready
// after reset the grid is cleared one cell a cycle, all GRID_WIDTH * GRID_HEIGHT cells
//   (4096 by default), with in_ch.ready low; configuration writes are taken throughout
// viewer registers return to their reset values and no result is pending after reset
module grid_dda_ray_caster #(
  parameter int GRID_WIDTH     = gdrc_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT    = gdrc_pkg::GRID_HEIGHT_DEF,
  parameter int SCREEN_COLUMNS = gdrc_pkg::SCREEN_COLUMNS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gdrc_in_if.sink                                in_ch,
  gdrc_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [gdrc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [gdrc_pkg::CFG_W-1:0]        cfg_wdata
);
  // command and status between sequencer and datapath
  gdrc_pkg::ctrl_cmd_t cmd;
  gdrc_pkg::dp_stat_t  stat;

  // sequencer: clearing pass, set-up, walk and result hand-off
  gdrc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: registers, grid memory, divider, walk and output register
  gdrc_dp #(
    .GRID_WIDTH     (GRID_WIDTH),
    .GRID_HEIGHT    (GRID_HEIGHT),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire

// ----- tb/grid_dda_ray_caster_check.sv -----
`default_nettype none

module grid_dda_ray_caster_check (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  gdrc_in_if                                   in_ch,
  gdrc_out_if                                  out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [gdrc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [gdrc_pkg::CFG_W-1:0]      cfg_wdata,
  output int                                   fails,
  output int                                   pending
);
  import gdrc_pkg::*;

  localparam longint unsigned SAT = 64'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [CELL_W-1:0] hx;
    logic [CELL_W-1:0] hy;
    logic              side;
    logic [DIST_W-1:0] sdx;
    logic [DIST_W-1:0] sdy;
    logic              oom;
  } ray_hit_t;

  logic [CODE_W-1:0] cells [0:GRID_WIDTH_DEF*GRID_HEIGHT_DEF-1];
  logic [POS_W-1:0]  px, py;
  longint            vdx, vdy, vpx, vpy;
  ray_hit_t          hits_due [$];

  function automatic longint unsigned step_len(longint ray);
    longint unsigned mag, d;
    mag = (ray < 0) ? -ray : ray;
    if (mag == 0) return SAT;
    d = (64'd1 << 32) / mag;
    return (d > SAT) ? SAT : d;
  endfunction

  function automatic longint unsigned first_edge(longint ray, logic [POS_W-1:0] p,
                                                 longint unsigned d);
    longint unsigned f, s;
    f = (ray < 0) ? longint'(p[FRAC_W-1:0]) : 65536 - longint'(p[FRAC_W-1:0]);
    s = (f * d) >> 16;
    return (s > SAT) ? SAT : s;
  endfunction

  function automatic ray_hit_t trace_ray(logic [COL_W-1:0] col);
    longint cam, rx, ry, mx, my, stx, sty;
    longint unsigned ddx, ddy, sx, sy;
    bit outside, side;
    ray_hit_t r;
    cam = longint'(col) * 128 - 65536;
    rx = vdx + ((vpx * cam) >>> 16);
    ry = vdy + ((vpy * cam) >>> 16);
    ddx = step_len(rx);
    ddy = step_len(ry);
    sx = first_edge(rx, px, ddx);
    sy = first_edge(ry, py, ddy);
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    mx = longint'(px >> 16);
    my = longint'(py >> 16);
    side = 0;
    outside = (mx >= GRID_WIDTH_DEF) || (my >= GRID_HEIGHT_DEF);
    while (!outside) begin
      if (sx < sy) begin
        sx = (sx + ddx > SAT) ? SAT : sx + ddx;
        mx += stx;
        side = 0;
      end else begin
        sy = (sy + ddy > SAT) ? SAT : sy + ddy;
        my += sty;
        side = 1;
      end
      if (mx < 0 || mx >= GRID_WIDTH_DEF || my < 0 || my >= GRID_HEIGHT_DEF) begin
        outside = 1;
        break;
      end
      if (cells[my * GRID_WIDTH_DEF + mx] == WALL_CODE) break;
    end
    r.hx = outside ? '0 : mx[CELL_W-1:0];
    r.hy = outside ? '0 : my[CELL_W-1:0];
    r.side = side;
    r.sdx = sx[DIST_W-1:0];
    r.sdy = sy[DIST_W-1:0];
    r.oom = outside;
    return r;
  endfunction

  task automatic report(string what, longint unsigned want, longint unsigned got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    ray_hit_t e;
    if (!rst_n) begin
      foreach (cells[i]) cells[i] = '0;
      px = POS_X_RST;
      py = POS_Y_RST;
      vdx = DIR_X_RST;
      vdy = DIR_Y_RST;
      vpx = PLANE_X_RST;
      vpy = PLANE_Y_RST;
      hits_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hits_due.size() == 0) begin
          report("results due", 0, 1);
        end else begin
          e = hits_due.pop_front();
          if (out_ch.hit_x !== e.hx) report("hit_x", e.hx, out_ch.hit_x);
          if (out_ch.hit_y !== e.hy) report("hit_y", e.hy, out_ch.hit_y);
          if (out_ch.hit_side !== e.side) report("hit_side", e.side, out_ch.hit_side);
          if (out_ch.dist_x_final !== e.sdx)
            report("dist_x_final", e.sdx, out_ch.dist_x_final);
          if (out_ch.dist_y_final !== e.sdy)
            report("dist_y_final", e.sdy, out_ch.dist_y_final);
          if (out_ch.out_of_map !== e.oom) report("out_of_map", e.oom, out_ch.out_of_map);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_CAST) hits_due.push_back(trace_ray(in_ch.column));
        else cells[in_ch.cell_y * GRID_WIDTH_DEF + in_ch.cell_x] = in_ch.cell_code;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_POS_X:   px = cfg_wdata[POS_W-1:0];
          CFG_POS_Y:   py = cfg_wdata[POS_W-1:0];
          CFG_DIR_X:   vdx = longint'($signed(cfg_wdata[DIR_W-1:0]));
          CFG_DIR_Y:   vdy = longint'($signed(cfg_wdata[DIR_W-1:0]));
          CFG_PLANE_X: vpx = longint'($signed(cfg_wdata[DIR_W-1:0]));
          CFG_PLANE_Y: vpy = longint'($signed(cfg_wdata[DIR_W-1:0]));
          default: ;
        endcase
      end
    end
    pending = hits_due.size();
  end

endmodule

`default_nettype wire

// ----- tb/grid_dda_ray_caster_test.sv -----
`default_nettype none

module grid_dda_ray_caster_test;
  import gdrc_pkg::*;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   fails, pending;
  bit                   no_gaps;
  int                   stall_left;

  gdrc_in_if  in_ch ();
  gdrc_out_if out_ch ();

  grid_dda_ray_caster DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  grid_dda_ray_caster_check checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .fails     (fails),
    .pending   (pending)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls, including stretches where it never stalls
  initial begin
    out_ch.ready = 0;
    stall_left = 0;
  end
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
      if (!no_gaps) stall_left <= pick_gap();
    end
  end

  // one input transfer, after a random gap
  task automatic send(op_t op, logic [COL_W-1:0] col, logic [CELL_W-1:0] cx,
                      logic [CELL_W-1:0] cy, logic [CODE_W-1:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.column <= col;
    in_ch.cell_x <= cx;
    in_ch.cell_y <= cy;
    in_ch.cell_code <= code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic cast(logic [COL_W-1:0] col);
    send(OP_CAST, col, $urandom, $urandom, $urandom);
  endtask

  task automatic put_cell(logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                          logic [CODE_W-1:0] code);
    send(OP_WRITE, $urandom, cx, cy, code);
  endtask

  // block drained: nothing due and the last cell write has settled
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_view(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [DIR_W-1:0] dx,
                          logic [DIR_W-1:0] dy, logic [DIR_W-1:0] plx,
                          logic [DIR_W-1:0] ply);
    logic [CFG_W-1:0] vals [6];
    cfg_idx_t idx [6];
    vals = '{x, y, CFG_W'(dx), CFG_W'(dy), CFG_W'(plx), CFG_W'(ply)};
    idx = '{CFG_POS_X, CFG_POS_Y, CFG_DIR_X, CFG_DIR_Y, CFG_PLANE_X, CFG_PLANE_Y};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_idx <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // random view, sometimes with a zero ray component on one axis
  task automatic random_view();
    logic [DIR_W-1:0] dy, ply;
    dy = $urandom;
    ply = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      dy = '0;
      ply = '0;
    end
    set_view($urandom, $urandom, $urandom, dy, $urandom, ply);
  endtask

  // one random item: a cast, or a cell write that is a wall with probability wall_pct
  task automatic random_item(int wall_pct);
    if ($urandom_range(0, 99) < 60) begin
      cast($urandom);
    end else if ($urandom_range(0, 99) < wall_pct) begin
      put_cell($urandom, $urandom, WALL_CODE);
    end else begin
      put_cell($urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = OP_WRITE;
    in_ch.column = '0;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    in_ch.cell_code = '0;
    no_gaps = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed: empty grid on reset view, edge columns, then a few walls
    cast(0);
    cast(1023);
    cast(512);
    put_cell(63, 63, 4'hF);
    put_cell(0, 0, WALL_CODE);
    put_cell(5, 0, WALL_CODE);
    put_cell(0, 5, WALL_CODE);
    put_cell(3, 3, 4'h2);
    cast(0);
    cast(1023);
    cast(511);
    drain();
    // viewer in the far corner cell, starting cell is a wall and is not tested
    set_view(22'h3F_FFFF, 22'h3F_FFFF, 18'h2_0000, 18'h1_FFFF, 18'h2_0000, 18'h2_0000);
    put_cell(63, 63, WALL_CODE);
    put_cell(62, 62, WALL_CODE);
    cast(0);
    cast(1023);
    cast(700);
    drain();
    // zero y ray component: y side distance pinned at saturation
    set_view(22'h20_8000, 22'h10_0000, 18'h1_FFFF, 18'h0, 18'h1_0000, 18'h0);
    cast(512);
    cast(0);
    cast(1023);
    drain();

    // random phases, each under its own view; the last at the extremes
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        set_view(22'h0, 22'h3F_FFFF, 18'h1_FFFF, 18'h2_0000, 18'h2_0000, 18'h1_FFFF);
      else
        random_view();
      for (int n = 0; n < 320; n++) begin
        if (n % 80 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        // hold off until every result is back
        if (ph == 2 && n == 160) begin
          in_ch.valid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_item(ph < 3 ? 70 : 30);
      end
      no_gaps = 0;
      drain();
    end

    repeat (400) @(posedge clk);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
